/* design/afs_pkg.sv */
package afs_pkg;

  localparam int FracBits = 16;
  localparam int DirBits = 16;
  localparam int GammaBits = 16;
  localparam int LamLimShift = FracBits + (32 - FracBits) / 2;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StZero    = 2'd1,
    StSat     = 2'd2,
    StUnused  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegPeak = 2'd0,
    RegDirX = 2'd1,
    RegDirY = 2'd2,
    RegDirZ = 2'd3
  } reg_idx_e;

  // round(x / 2^sh), ties away from zero
  function automatic logic signed [127:0] rshr(input logic signed [127:0] x, input int sh);
    logic [127:0] mag;
    logic [127:0] q;
    mag = x[127] ? 128'(-x) : 128'(x);
    q = (mag + (128'(1) << (sh - 1))) >> sh;
    return x[127] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v, output logic s);
    s = 1'b0;
    if (v > 128'sd2147483647) begin
      s = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      s = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* design/afs_sqrt.sv */
// pipelined digit-recurrence integer square root, one result bit per stage
module afs_sqrt import afs_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [65:0] rad_i,
  output logic [32:0] root_o
);
  localparam int Steps = 33;

  logic [65:0] rem_q [Steps];
  logic [32:0] res_q [Steps];
  logic [65:0] val_q [Steps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        logic [65:0] v, r, t;
        logic [32:0] q;
        v = (s == 0) ? rad_i : val_q[s-1];
        r = (s == 0) ? 66'd0 : rem_q[s-1];
        q = (s == 0) ? 33'd0 : res_q[s-1];
        r = {r[63:0], v[65:64]};
        t = {31'd0, q, 2'b01};
        if (r >= t) begin
          r = r - t;
          q = {q[31:0], 1'b1};
        end else begin
          q = {q[31:0], 1'b0};
        end
        rem_q[s] <= r;
        res_q[s] <= q;
        val_q[s] <= {v[63:0], 2'b00};
      end
    end
  end

  assign root_o = res_q[Steps-1];
endmodule

/* design/afs_div.sv */
// pipelined restoring divider for n_i = round(a_i * 2^F / L), 49 quotient bits
module afs_div import afs_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] num_i,
  input  logic [32:0]        den_i,
  output logic signed [31:0] quo_o
);
  localparam int QBits = 32 + FracBits + 1;

  logic [QBits-1:0] num_q [QBits+1];
  logic [33:0]      rem_q [QBits+1];
  logic [QBits-1:0] quo_q [QBits+1];
  logic [32:0]      den_q [QBits+1];
  logic             neg_q [QBits+1];
  logic signed [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [31:0] mag;
      mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
      // doubled numerator plus one denominator gives half-up rounding
      num_q[0] <= QBits'({mag, {(FracBits + 1){1'b0}}});
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[31];
      for (int s = 0; s < QBits; s++) begin
        logic [33:0] r;
        r = {rem_q[s][32:0], num_q[s][QBits-1]};
        num_q[s+1] <= {num_q[s][QBits-2:0], 1'b0};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (r >= {1'b0, den_q[s]}) begin
          rem_q[s+1] <= r - {1'b0, den_q[s]};
          quo_q[s+1] <= {quo_q[s][QBits-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= r;
          quo_q[s+1] <= {quo_q[s][QBits-2:0], 1'b0};
        end
      end
      begin
        logic [QBits-1:0] q;
        q = (quo_q[QBits] + 1'b1) >> 1;
        out_q <= neg_q[QBits] ? -$signed(32'(q)) : $signed(32'(q));
      end
    end
  end

  assign quo_o = out_q;
endmodule

/* design/active_fiber_stress.sv */
// active fiber stress: one material point per beat, one result beat each.
// a new point can be taken every cycle unless stalled; the pipeline
// (matrix-vector stage, 33-stage square root, 51-stage divider for the unit
// fiber vector, then outer product and scaling) has 87 register stages. the
// force-length factor and the scale c run in six stages beside the divider.
// the whole pipeline advances only when the output register is free or being
// taken, so a stall on the result side holds every stage. config writes are
// taken any time but must only be issued while idle.
module active_fiber_stress import afs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] grad_xx_i, grad_xy_i, grad_xz_i,
  input  logic signed [31:0] grad_yx_i, grad_yy_i, grad_yz_i,
  input  logic signed [31:0] grad_zx_i, grad_zy_i, grad_zz_i,
  input  logic [16:0] activation_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] stress_xx_o, stress_yy_o, stress_zz_o,
  output logic signed [31:0] stress_xy_o, stress_yz_o, stress_xz_o,
  output logic [1:0]  status_o
);
  localparam int SqLat = 33;
  localparam int DvLat = 32 + FracBits + 3;
  localparam int Depth = 1 + SqLat + DvLat + 2;
  // length of the c delay line: divider depth less the force-length stages ahead of it
  localparam int CLat = DvLat - 5;
  localparam int LamW = LamLimShift + 1;
  localparam int SqW = 2 * LamW;
  // ceil(2^39 / 9), exact floor(m / 9) for every m below 2^39
  localparam logic [35:0] Recip9 = 36'd61083979321;
  localparam logic signed [55:0] FlOffset = 56'sd756 <<< (FracBits + 6);

  logic [30:0] peak_q;
  logic signed [17:0] dir_q [3];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      dir_q[0] <= 18'sd65536;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegPeak: peak_q <= cfg_data_i[30:0];
        RegDirX: dir_q[0] <= cfg_data_i[17:0];
        RegDirY: dir_q[1] <= cfg_data_i[17:0];
        RegDirZ: dir_q[2] <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // global advance: all stages move together
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_valid};
  end

  // stage 1: fiber vector a = F*a0
  logic signed [31:0] a1_q [3];
  logic        sat1_q;
  logic [16:0] gam1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [31:0] g [9];
      logic s, sa;
      g = '{grad_xx_i, grad_xy_i, grad_xz_i, grad_yx_i, grad_yy_i, grad_yz_i,
            grad_zx_i, grad_zy_i, grad_zz_i};
      sa = 1'b0;
      for (int i = 0; i < 3; i++) begin
        logic signed [127:0] acc;
        acc = 128'(g[3*i] * dir_q[0]) + 128'(g[3*i+1] * dir_q[1])
            + 128'(g[3*i+2] * dir_q[2]);
        a1_q[i] <= sat32(rshr(acc, DirBits), s);
        sa = sa | s;
      end
      sat1_q <= sa;
      gam1_q <= (activation_i > 17'd65536) ? 17'd65536 : activation_i;
    end
  end

  logic [65:0] sum1;
  always_comb begin
    sum1 = '0;
    for (int i = 0; i < 3; i++) begin
      logic [31:0] m;
      m = a1_q[i][31] ? 32'(-a1_q[i]) : 32'(a1_q[i]);
      sum1 = sum1 + 66'(m * m);
    end
  end

  logic [32:0] lam_s;
  afs_sqrt u_sqrt (.clk_i, .en_i(adv), .rad_i(sum1), .root_o(lam_s));

  // delay side data through the root
  logic signed [31:0] ad_q [SqLat][3];
  logic [SqLat-1:0]   sd_q;
  logic [16:0]        gd_q [SqLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ad_q[0] <= a1_q;
      gd_q[0] <= gam1_q;
      for (int s = 1; s < SqLat; s++) begin
        ad_q[s] <= ad_q[s-1];
        gd_q[s] <= gd_q[s-1];
      end
      sd_q <= {sd_q[SqLat-2:0], sat1_q};
    end
  end

  logic signed [31:0] a2 [3];
  assign a2 = ad_q[SqLat-1];

  // unit vector through three dividers
  logic signed [31:0] n_s [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    afs_div u_div (.clk_i, .en_i(adv), .num_i(a2[i]), .den_i(lam_s), .quo_o(n_s[i]));
  end

  // force-length factor and scale c, six stages once lam is known, then delayed
  logic [SqW-1:0]     fa_sq_q;
  logic [LamW-1:0]    fa_lam_q;
  logic [47:0]        fa_pg_q;
  logic               fa_big_q, fa_zl_q, fa_sat_q;
  logic [38:0]        fb_m_q;
  logic [30:0]        fb_pg_q;
  logic               fb_neg_q, fb_big_q, fb_zl_q, fb_sat_q;
  logic [56:0]        fc_ph_q, fc_pl_q;
  logic [30:0]        fc_pg_q;
  logic               fc_neg_q, fc_big_q, fc_zl_q, fc_sat_q;
  logic signed [31:0] fd_f_q;
  logic [30:0]        fd_pg_q;
  logic               fd_zl_q, fd_sat_q;
  logic signed [63:0] fe_prod_q;
  logic               fe_zl_q, fe_sat_q;
  logic signed [31:0] c_q [CLat];
  logic               zl_q [CLat];
  logic               sc_q [CLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [55:0] x;
      logic [55:0] mg;
      logic [75:0] pr;
      logic [36:0] mq;
      logic signed [127:0] fw;
      logic signed [31:0] f;
      logic s1, s2;
      // lam squared on the bits below the limit, pmax * gamma
      fa_sq_q <= SqW'(lam_s[LamW-1:0]) * SqW'(lam_s[LamW-1:0]);
      fa_lam_q <= lam_s[LamW-1:0];
      fa_big_q <= (lam_s > (33'd1 << LamLimShift));
      fa_zl_q <= (lam_s == '0);
      fa_sat_q <= sd_q[SqLat-1];
      fa_pg_q <= 48'(peak_q) * 48'(gd_q[SqLat-1]);
      // polynomial, then magnitude rounded and split as 9216 = 9 * 2^10
      x = $signed(56'(fa_lam_q)) * 56'sd96000
        - $signed(56'(fa_sq_q >> (FracBits - 6))) * 56'sd625 - FlOffset;
      mg = x[55] ? 56'(-x) : 56'(x);
      fb_m_q <= 39'((mg + 56'd4608) >> 10);
      fb_neg_q <= x[55];
      fb_big_q <= fa_big_q;
      fb_zl_q <= fa_zl_q;
      fb_sat_q <= fa_sat_q;
      fb_pg_q <= 31'((fa_pg_q + (48'd1 << (GammaBits - 1))) >> GammaBits);
      // divide by 9 through the reciprocal, in two partial products
      fc_ph_q <= 57'(fb_m_q) * 57'(Recip9[35:18]);
      fc_pl_q <= 57'(fb_m_q) * 57'(Recip9[17:0]);
      fc_neg_q <= fb_neg_q;
      fc_big_q <= fb_big_q;
      fc_zl_q <= fb_zl_q;
      fc_sat_q <= fb_sat_q;
      fc_pg_q <= fb_pg_q;
      // f with sign and clamp, pinned past the stretch limit
      pr = (76'(fc_ph_q) << 18) + 76'(fc_pl_q);
      mq = pr[75:39];
      fw = fc_neg_q ? -$signed(128'(mq)) : $signed(128'(mq));
      f = sat32(fw, s1);
      if (fc_big_q) begin
        f = 32'sh80000000;
        s1 = 1'b1;
      end
      fd_f_q <= f;
      fd_sat_q <= fc_sat_q | s1;
      fd_zl_q <= fc_zl_q;
      fd_pg_q <= fc_pg_q;
      // pg * f
      fe_prod_q <= $signed({1'b0, fd_pg_q}) * fd_f_q;
      fe_zl_q <= fd_zl_q;
      fe_sat_q <= fd_sat_q;
      // c
      c_q[0] <= sat32(rshr(128'(fe_prod_q), FracBits), s2);
      sc_q[0] <= fe_sat_q | s2;
      zl_q[0] <= fe_zl_q;
      for (int s = 1; s < CLat; s++) begin
        c_q[s] <= c_q[s-1];
        sc_q[s] <= sc_q[s-1];
        zl_q[s] <= zl_q[s-1];
      end
    end
  end

  // outer product
  localparam int Ri [6] = '{0, 1, 2, 0, 1, 0};
  localparam int Ci [6] = '{0, 1, 2, 1, 2, 2};
  logic signed [31:0] p_q [6];
  logic signed [31:0] c2_q;
  logic zl2_q, sc2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++)
        p_q[k] <= 32'(rshr(128'(n_s[Ri[k]] * n_s[Ci[k]]), FracBits));
      c2_q <= c_q[CLat-1];
      zl2_q <= zl_q[CLat-1];
      sc2_q <= sc_q[CLat-1];
    end
  end

  // final scaling into the output register
  logic signed [31:0] s_q [6];
  logic [1:0] st_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic sa, s;
      sa = sc2_q;
      for (int k = 0; k < 6; k++) begin
        s_q[k] <= zl2_q ? 32'sd0 : sat32(rshr(128'(c2_q * p_q[k]), FracBits), s);
        sa = sa | (s & !zl2_q);
      end
      st_q <= zl2_q ? StZero : (sa ? StSat : StOk);
    end
  end

  assign out_valid = vld_q[Depth-1];
  assign stress_xx_o = s_q[0];
  assign stress_yy_o = s_q[1];
  assign stress_zz_o = s_q[2];
  assign stress_xy_o = s_q[3];
  assign stress_yz_o = s_q[4];
  assign stress_xz_o = s_q[5];
  assign status_o = st_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(stress_xx_o))
    else $error("result lost under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> out_valid && out_stall) else $error("stall without cause");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o == StZero |-> stress_xx_o == 0 && stress_yy_o == 0)
    else $error("zero stretch gave stress");
endmodule
